// ----- hw/rtl/ptm_pkg.sv -----
// ptm_pkg: shared types, codes and helpers of the sv39 page table mapper
`timescale 1ns / 1ps
package ptm_pkg;

  localparam int VPN_W       = 9;
  localparam int TABLE_SLOTS = 512;
  localparam int PAGE_SHIFT  = 12;
  localparam int PPN_W       = 44;
  localparam int VA_W        = 39;
  localparam int PTE_W       = 54;

  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_MAP    = 3'd1;
  localparam logic [2:0] CMD_SET    = 3'd2;
  localparam logic [2:0] CMD_FAULT  = 3'd3;
  localparam logic [2:0] CMD_FREE   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_NOPAGES  = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam logic [1:0] REG_POOL_BASE = 2'd0;
  localparam logic [1:0] REG_WIN_START = 2'd1;
  localparam logic [1:0] REG_WIN_END   = 2'd2;

  localparam logic [7:0] FLAG_V = 8'h01;
  localparam logic [7:0] FLAG_R = 8'h02;
  localparam logic [7:0] FLAG_W = 8'h04;
  localparam logic [7:0] FLAG_U = 8'h10;
  localparam logic [7:0] FLAG_A = 8'h40;
  localparam logic [7:0] FLAG_D = 8'h80;
  localparam logic [7:0] FLAG_VAD = FLAG_V | FLAG_A | FLAG_D;

  typedef struct packed {
    logic [PPN_W-1:0] pool_base;
    logic [VA_W-1:0]  win_start;
    logic [VA_W-1:0]  win_end;
  } ptm_cfg_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD2, S_W2, S_W1, S_W0, S_CHK, S_POP_RD, S_POP_GET,
    S_CLR, S_WR_TBL, S_WR_LEAF, S_FREE, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    POP_DATA, POP_L1, POP_L0
  } pop_sel_t;

  function automatic logic [PTE_W-1:0] make_pte(input logic [PPN_W-1:0] base,
                                                 input logic [PPN_W-1:0] page,
                                                 input logic [7:0] flags);
    logic [PPN_W-1:0] ppn;
    ppn = base + page;
    return {ppn, 2'b00, flags};
  endfunction

endpackage

// ----- hw/rtl/ptm_ram.sv -----
// ptm_ram: generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module ptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/ptm_walker.sv -----
// ptm_walker: command sequencer, table walk and page allocator over the pte and stack rams
`timescale 1ns / 1ps
module ptm_walker #(
  parameter int POOL_PAGES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ptm_pkg::ptm_cfg_t      cfg,
  input  logic                   start,
  input  logic [2:0]             command,
  input  logic [ptm_pkg::VA_W-1:0]  vaddr,
  input  logic [7:0]             perm_flags,
  input  logic [ptm_pkg::PPN_W-1:0] page_number,
  output logic                   busy,
  output logic                   done,
  output logic [1:0]             status,
  output logic [ptm_pkg::PPN_W-1:0] leaf_page,
  output logic [7:0]             leaf_flags
);
  import ptm_pkg::*;

  localparam int PG_W   = $clog2(POOL_PAGES);
  localparam int ADDR_W = PG_W + VPN_W;
  localparam int DEPTH  = POOL_PAGES * TABLE_SLOTS;
  localparam int CNT_W  = PG_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [PPN_W-1:0]  POOL_LIM  = PPN_W'(POOL_PAGES);

  state_t state, state_next;
  pop_sel_t sel;

  logic [2:0]        cmd_q;
  logic [VA_W-1:0]   va_q;
  logic [7:0]        flags_q;
  logic [PPN_W-1:0]  pn_q;
  logic              have1, have0;
  logic [1:0]        need;
  logic [PG_W-1:0]   pg1, pg0, data_pg;
  logic [VPN_W-1:0]  clr_cnt;
  logic [ADDR_W-1:0] init_cnt;
  logic [CNT_W-1:0]  free_count;
  logic [1:0]        status_q;
  logic [PPN_W-1:0]  leaf_page_q;
  logic [7:0]        leaf_flags_q;

  logic              pte_we;
  logic [ADDR_W-1:0] pte_waddr, pte_raddr;
  logic [PTE_W-1:0]  pte_wdata, pte_rdata;
  logic              stk_we;
  logic [PG_W-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic [VPN_W-1:0]  v2, v1, v0;
  logic [PPN_W-1:0]  idx_rd, free_idx;
  logic              rd_valid, in_pool, is_map, in_window, free_bad;

  assign v2 = va_q[38:30];
  assign v1 = va_q[29:21];
  assign v0 = va_q[20:PAGE_SHIFT];

  assign rd_valid = pte_rdata[0];
  assign idx_rd   = pte_rdata[PTE_W-1:10] - cfg.pool_base;
  assign in_pool  = idx_rd < POOL_LIM;
  assign is_map   = (cmd_q == CMD_MAP) || (cmd_q == CMD_FAULT);
  assign in_window = !(vaddr < cfg.win_start) && !(vaddr > cfg.win_end);
  assign free_idx = pn_q - cfg.pool_base;
  assign free_bad = (free_idx == '0) || !(free_idx < POOL_LIM)
                    || !(free_count < CNT_W'(POOL_PAGES));

  ptm_ram #(.WIDTH(PTE_W), .DEPTH(DEPTH)) u_pte_ram (
    .clk(clk), .we(pte_we), .waddr(pte_waddr), .wdata(pte_wdata),
    .raddr(pte_raddr), .rdata(pte_rdata)
  );

  ptm_ram #(.WIDTH(PG_W), .DEPTH(POOL_PAGES)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:    if (init_cnt == LAST_ADDR) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (command) inside
            CMD_LOOKUP, CMD_SET, CMD_MAP: state_next = S_RD2;
            CMD_FAULT: state_next = in_window ? S_RD2 : S_DONE;
            CMD_FREE:  state_next = S_FREE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RD2:     state_next = S_W2;
      S_W2: begin
        if (!rd_valid) state_next = is_map ? S_CHK : S_DONE;
        else if (!in_pool) state_next = S_DONE;
        else state_next = S_W1;
      end
      S_W1: begin
        if (!rd_valid) state_next = is_map ? S_CHK : S_DONE;
        else if (!in_pool) state_next = S_DONE;
        else state_next = is_map ? S_CHK : S_W0;
      end
      S_W0:      state_next = S_DONE;
      S_CHK:     state_next = (free_count < CNT_W'(need)) ? S_DONE : S_POP_RD;
      S_POP_RD:  state_next = S_POP_GET;
      S_POP_GET: begin
        if (sel == POP_DATA) state_next = (!have1 || !have0) ? S_POP_RD : S_WR_LEAF;
        else state_next = S_CLR;
      end
      S_CLR:     if (clr_cnt == VPN_W'(TABLE_SLOTS - 1)) state_next = S_WR_TBL;
      S_WR_TBL:  state_next = (sel == POP_L1) ? S_POP_RD : S_WR_LEAF;
      S_WR_LEAF: state_next = S_DONE;
      S_FREE:    state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pte_we    = 1'b0;
    pte_waddr = '0;
    pte_wdata = '0;
    pte_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    unique case (state)
      S_INIT: begin
        // zero every pte and load the free stack with pages top-down
        pte_we    = 1'b1;
        pte_waddr = init_cnt;
        stk_we    = init_cnt < ADDR_W'(POOL_PAGES);
        stk_waddr = init_cnt[PG_W-1:0];
        stk_wdata = PG_W'(POOL_PAGES - 1) - init_cnt[PG_W-1:0];
      end
      S_RD2: pte_raddr = {PG_W'(0), v2};
      S_W2:  pte_raddr = {idx_rd[PG_W-1:0], v1};
      S_W1:  pte_raddr = {idx_rd[PG_W-1:0], v0};
      S_W0: begin
        pte_we    = (cmd_q == CMD_SET) && rd_valid;
        pte_waddr = {pg0, v0};
        pte_wdata = {pte_rdata[PTE_W-1:8], flags_q | FLAG_VAD};
      end
      S_POP_RD: stk_raddr = PG_W'(free_count - 1'b1);
      S_CLR: begin
        pte_we    = 1'b1;
        pte_waddr = {(sel == POP_L1) ? pg1 : pg0, clr_cnt};
      end
      S_WR_TBL: begin
        pte_we = 1'b1;
        if (sel == POP_L1) begin
          pte_waddr = {PG_W'(0), v2};
          pte_wdata = make_pte(cfg.pool_base, PPN_W'(pg1), FLAG_V);
        end else begin
          pte_waddr = {pg1, v1};
          pte_wdata = make_pte(cfg.pool_base, PPN_W'(pg0), FLAG_V);
        end
      end
      S_WR_LEAF: begin
        pte_we    = 1'b1;
        pte_waddr = {pg0, v0};
        pte_wdata = make_pte(cfg.pool_base, PPN_W'(data_pg), flags_q | FLAG_VAD);
      end
      S_FREE: begin
        stk_we    = !free_bad;
        stk_waddr = free_count[PG_W-1:0];
        stk_wdata = free_idx[PG_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt   <= '0;
      free_count <= CNT_W'(POOL_PAGES - 1);
      clr_cnt    <= '0;
      sel        <= POP_DATA;
    end else begin
      case (state)
        S_INIT: init_cnt <= init_cnt + 1'b1;
        S_IDLE: begin
          if (start) begin
            cmd_q   <= command;
            va_q    <= (command == CMD_FAULT) ? {vaddr[VA_W-1:PAGE_SHIFT], 12'b0} : vaddr;
            flags_q <= (command == CMD_FAULT) ? (FLAG_R | FLAG_W | FLAG_U) : perm_flags;
            pn_q    <= page_number;
            have1   <= 1'b0;
            have0   <= 1'b0;
            sel     <= POP_DATA;
            status_q     <= ST_RANGE;
            leaf_page_q  <= '0;
            leaf_flags_q <= '0;
          end
        end
        S_W2: begin
          if (!rd_valid) begin
            need     <= 2'd3;
            status_q <= ST_UNMAPPED;
          end else if (in_pool) begin
            pg1   <= idx_rd[PG_W-1:0];
            have1 <= 1'b1;
          end
        end
        S_W1: begin
          if (!rd_valid) begin
            need     <= 2'd2;
            status_q <= ST_UNMAPPED;
          end else if (in_pool) begin
            pg0   <= idx_rd[PG_W-1:0];
            have0 <= 1'b1;
            need  <= 2'd1;
          end
        end
        S_W0: begin
          if (rd_valid) begin
            status_q     <= ST_OK;
            leaf_page_q  <= pte_rdata[PTE_W-1:10];
            leaf_flags_q <= (cmd_q == CMD_SET) ? (flags_q | FLAG_VAD) : pte_rdata[7:0];
          end else begin
            status_q <= ST_UNMAPPED;
          end
        end
        S_CHK:    status_q <= ST_NOPAGES;
        S_POP_RD: free_count <= free_count - 1'b1;
        S_POP_GET: begin
          clr_cnt <= '0;
          case (sel)
            POP_DATA: begin
              data_pg <= stk_rdata;
              sel     <= have1 ? POP_L0 : POP_L1;
            end
            POP_L1:  pg1 <= stk_rdata;
            default: pg0 <= stk_rdata;
          endcase
        end
        S_CLR:    clr_cnt <= clr_cnt + 1'b1;
        S_WR_TBL: if (sel == POP_L1) sel <= POP_L0;
        S_WR_LEAF: begin
          status_q     <= ST_OK;
          leaf_page_q  <= cfg.pool_base + PPN_W'(data_pg);
          leaf_flags_q <= flags_q | FLAG_VAD;
        end
        S_FREE: begin
          if (!free_bad) begin
            status_q   <= ST_OK;
            free_count <= free_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign status     = status_q;
  assign leaf_page  = leaf_page_q;
  assign leaf_flags = leaf_flags_q;

endmodule

// ----- hw/rtl/sv39_page_table_mapper_unit.sv -----
// sv39_page_table_mapper_unit: top level with configuration registers and the walker
`timescale 1ns / 1ps
// Sv39 page table engine over a pool of POOL_PAGES physical pages.
// Command channel: a beat is taken when start is high and busy is low; it carries
// command, vaddr, perm_flags and page_number. One result beat follows each command:
// done is high for one cycle with status, leaf_page and leaf_flags.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 pool base page, 1 user window start, 2 user window end.
// Unknown commands and faults outside the window finish without a table read, a page
// release touches only the free stack, lookup and set_flags walk down to the leaf,
// and a map or fault stops early on a bad table pointer or a short free stack.
// Every table that a map has to allocate adds a clearing sweep over its 512 slots.
// Each step is bound by the single pte ram, read one level at a time with a
// registered read. One command is in flight at a time.
// After reset the pte ram is zeroed and the free stack loaded, one entry a cycle and
// POOL_PAGES*512 entries in all (32768 at the default), with busy high.
// The receiver cannot stall; done marks a result for its single done cycle only.
module sv39_page_table_mapper_unit #(
  parameter int POOL_PAGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [38:0] vaddr,
  input  logic [7:0]  perm_flags,
  input  logic [43:0] page_number,
  output logic        done,
  output logic [1:0]  status,
  output logic [43:0] leaf_page,
  output logic [7:0]  leaf_flags,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [43:0] cfg_data
);
  import ptm_pkg::*;

  ptm_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_base <= PPN_W'(524800);
      cfg.win_start <= VA_W'(64'd3221225472);
      cfg.win_end   <= VA_W'(64'd3489660928);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POOL_BASE: cfg.pool_base <= cfg_data;
        REG_WIN_START: cfg.win_start <= cfg_data[VA_W-1:0];
        REG_WIN_END:   cfg.win_end   <= cfg_data[VA_W-1:0];
        default: ;
      endcase
    end
  end

  ptm_walker #(.POOL_PAGES(POOL_PAGES)) u_walker (
    .clk(clk), .rst(rst), .cfg(cfg),
    .start(start), .command(command), .vaddr(vaddr), .perm_flags(perm_flags),
    .page_number(page_number), .busy(busy), .done(done), .status(status),
    .leaf_page(leaf_page), .leaf_flags(leaf_flags)
  );
endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for the sv39 page table mapper, predictor and random commands
`timescale 1ns / 1ps
module tb_top;
  import ptm_pkg::*;

  localparam int POOL = 64;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [43:0] PPN_MAX = 44'hFFF_FFFF_FFFF;
  localparam logic [38:0] VA_MAX = 39'h7F_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  st;
    logic [43:0] page;
    logic [7:0]  flags;
  } leaf_result_t;

  class mapper_scoreboard;
    logic [53:0] pte [0:POOL*512-1];
    bit          vld [0:POOL*512-1];
    logic [5:0]  stk [0:POOL-1];
    int          cnt;
    logic [43:0] base;
    logic [38:0] ws, we;
    leaf_result_t pending[$];
    int          errors;

    function new();
      for (int i = 0; i < POOL*512; i++) vld[i] = 0;
      for (int i = 0; i < POOL; i++) stk[i] = 0;
      cnt = POOL - 1;
      for (int i = 0; i < POOL - 1; i++) stk[i] = 6'(POOL - 1 - i);
      base = 44'd524800;
      ws = 39'd3221225472;
      we = 39'd3489660928;
      errors = 0;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [43:0] val);
      if (idx == REG_POOL_BASE) base = val;
      else if (idx == REG_WIN_START) ws = val[38:0];
      else if (idx == REG_WIN_END) we = val[38:0];
    endfunction

    function logic [53:0] rd(int page, logic [8:0] slot);
      int i;
      i = page * 512 + slot;
      return vld[i] ? pte[i] : 54'd0;
    endfunction

    function void wr(int page, logic [8:0] slot, logic [53:0] v);
      int i;
      i = page * 512 + slot;
      pte[i] = v;
      vld[i] = 1;
    endfunction

    function logic [53:0] mk(int page, logic [7:0] f);
      logic [43:0] p;
      p = base + 44'(page);
      return {p, 2'b00, f};
    endfunction

    function bit in_pool(logic [53:0] e, output int pg);
      logic [43:0] d;
      d = e[53:10] - base;
      pg = 0;
      if (d >= POOL) return 0;
      pg = int'(d);
      return 1;
    endfunction

    function int pop();
      int p;
      p = 0;
      if (cnt > 0) begin
        cnt--;
        p = stk[cnt];
      end
      return p;
    endfunction

    function void clear(int page);
      for (int i = 0; i < 512; i++) vld[page*512 + i] = 0;
    endfunction

    function logic [1:0] walk(logic [38:0] va, output int pg0);
      logic [53:0] e2, e1;
      int pg1;
      pg0 = 0;
      e2 = rd(0, va[38:30]);
      if (!e2[0]) return ST_UNMAPPED;
      if (!in_pool(e2, pg1)) return ST_RANGE;
      e1 = rd(pg1, va[29:21]);
      if (!e1[0]) return ST_UNMAPPED;
      if (!in_pool(e1, pg0)) return ST_RANGE;
      return ST_OK;
    endfunction

    function logic [1:0] do_map(logic [38:0] va, logic [7:0] fl, output logic [53:0] leaf);
      logic [53:0] e2, e1;
      int pg1, pg0, need, data;
      bit have1, have0;
      leaf = 0;
      pg1 = 0;
      pg0 = 0;
      need = 1;
      have0 = 0;
      e2 = rd(0, va[38:30]);
      have1 = e2[0];
      if (have1) begin
        if (!in_pool(e2, pg1)) return ST_RANGE;
        e1 = rd(pg1, va[29:21]);
        have0 = e1[0];
        if (have0) begin
          if (!in_pool(e1, pg0)) return ST_RANGE;
        end else begin
          need += 1;
        end
      end else begin
        need += 2;
      end
      if (cnt < need) return ST_NOPAGES;
      data = pop();
      if (!have1) begin
        pg1 = pop();
        clear(pg1);
        wr(0, va[38:30], mk(pg1, FLAG_V));
      end
      if (!have0) begin
        pg0 = pop();
        clear(pg0);
        wr(pg1, va[29:21], mk(pg0, FLAG_V));
      end
      leaf = mk(data, fl | FLAG_VAD);
      wr(pg0, va[20:12], leaf);
      return ST_OK;
    endfunction

    // accepted command beat: update the mirror and queue the leaf it should report
    function void note(logic [2:0] cmd, logic [38:0] va, logic [7:0] pf, logic [43:0] pn);
      leaf_result_t r;
      logic [53:0] leaf;
      logic [43:0] d;
      int pg0;
      leaf = 0;
      r.st = ST_RANGE;
      case (cmd) inside
        CMD_LOOKUP, CMD_SET: begin
          r.st = walk(va, pg0);
          if (r.st == ST_OK) begin
            leaf = rd(pg0, va[20:12]);
            if (!leaf[0]) begin
              r.st = ST_UNMAPPED;
            end else if (cmd == CMD_SET) begin
              leaf[7:0] = pf | FLAG_VAD;
              wr(pg0, va[20:12], leaf);
            end
          end
        end
        CMD_MAP: r.st = do_map(va, pf, leaf);
        CMD_FAULT: begin
          if (va >= ws && va <= we)
            r.st = do_map({va[38:12], 12'h000}, FLAG_R | FLAG_W | FLAG_U, leaf);
        end
        CMD_FREE: begin
          d = pn - base;
          if (d != 0 && d < POOL && cnt < POOL) begin
            stk[cnt] = d[5:0];
            cnt++;
            r.st = ST_OK;
          end
        end
        default: r.st = ST_RANGE;
      endcase
      if (r.st != ST_OK) leaf = 0;
      r.page = leaf[53:10];
      r.flags = leaf[7:0];
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic [1:0] st, logic [43:0] page, logic [7:0] flags);
      leaf_result_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing outstanding");
      end else begin
        e = pending.pop_front();
        if (st !== e.st) report($sformatf("status %0d want %0d", st, e.st));
        if (page !== e.page) report($sformatf("leaf_page %h want %h", page, e.page));
        if (flags !== e.flags) report($sformatf("leaf_flags %h want %h", flags, e.flags));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [2:0] command = 0;
  logic [38:0] vaddr = 0;
  logic [7:0] perm_flags = 0;
  logic [43:0] page_number = 0;
  logic done;
  logic [1:0] status;
  logic [43:0] leaf_page;
  logic [7:0] leaf_flags;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [43:0] cfg_data = 0;

  mapper_scoreboard sb;
  int cycles = 0;
  logic [38:0] recent_va[$];

  sv39_page_table_mapper_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .vaddr(vaddr), .perm_flags(perm_flags), .page_number(page_number),
    .done(done), .status(status), .leaf_page(leaf_page), .leaf_flags(leaf_flags),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sv39_page_table_mapper_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(status, leaf_page, leaf_flags);
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // leaves the start high; the caller drops it when a gap follows
  task automatic issue(logic [2:0] cmd, logic [38:0] va, logic [7:0] pf, logic [43:0] pn);
    start <= 1;
    command <= cmd;
    vaddr <= va;
    perm_flags <= pf;
    page_number <= pn;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(cmd, va, pf, pn);
  endtask

  task automatic gap(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [43:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_cfg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // mostly a handful of table slots so tables get reused
  function automatic logic [38:0] table_va();
    logic [8:0] v2, v1;
    logic [38:0] va;
    case ($urandom_range(0, 4))
      0: v2 = 0; 1: v2 = 1; 2: v2 = 3; 3: v2 = 9'h1FF; default: v2 = 2;
    endcase
    case ($urandom_range(0, 2))
      0: v1 = 0; 1: v1 = 1; default: v1 = 9'h1FF;
    endcase
    va = 39'(rnd64());
    va[38:30] = v2;
    va[29:21] = v1;
    return va;
  endfunction

  function automatic logic [38:0] window_va();
    logic [63:0] span;
    if (sb.ws > sb.we || $urandom_range(0, 3) == 0) return 39'(rnd64());
    span = 64'(sb.we - sb.ws) + 1;
    return sb.ws + 39'(rnd64() % span);
  endfunction

  task automatic random_item();
    logic [38:0] va;
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      va = ($urandom_range(0, 9) == 0) ? 39'(rnd64()) : table_va();
      issue(CMD_MAP, va, 8'($urandom), 44'(rnd64()));
      recent_va.push_back(va);
      if (recent_va.size() > 16) void'(recent_va.pop_front());
    end else if (k < 60) begin
      if (recent_va.size() > 0 && $urandom_range(0, 3) != 0)
        va = recent_va[$urandom_range(0, recent_va.size() - 1)];
      else
        va = table_va();
      issue((k < 48) ? CMD_LOOKUP : CMD_SET, va, 8'($urandom), 44'(rnd64()));
    end else if (k < 73) begin
      issue(CMD_FAULT, window_va(), 8'($urandom), 44'(rnd64()));
    end else if (k < 95) begin
      case ($urandom_range(0, 4))
        0: issue(CMD_FREE, 39'(rnd64()), 8'($urandom), 44'(rnd64()));
        1: issue(CMD_FREE, 39'(rnd64()), 8'($urandom), sb.base + 44'($urandom_range(0, 70)));
        default: issue(CMD_FREE, 39'(rnd64()), 8'($urandom),
                       sb.base + 44'($urandom_range(1, POOL - 1)));
      endcase
    end else begin
      issue(3'($urandom_range(5, 7)), 39'(rnd64()), 8'($urandom), 44'(rnd64()));
    end
  endtask

  task automatic random_phase(int n, bit idle);
    for (int i = 0; i < n; i++) begin
      random_item();
      if (idle && $urandom_range(0, 3) == 0) gap($urandom_range(1, 18));
      if (idle && i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed corners
    issue(CMD_LOOKUP, 39'h0, 8'h00, 44'h0);
    issue(CMD_MAP, 39'h0, 8'h00, 44'h0);
    issue(CMD_MAP, VA_MAX, 8'hFF, PPN_MAX);
    issue(CMD_LOOKUP, 39'h0, 8'h00, 44'h0);
    issue(CMD_LOOKUP, VA_MAX, 8'h00, 44'h0);
    issue(CMD_LOOKUP, 39'h1000, 8'h00, 44'h0);
    issue(CMD_SET, VA_MAX, 8'hFF, 44'h0);
    issue(CMD_SET, 39'h2000, 8'h3E, 44'h0);
    issue(CMD_MAP, 39'h0, 8'h2A, 44'h0);
    gap(3);
    issue(CMD_FAULT, sb.ws - 39'd1, 8'h00, 44'h0);
    issue(CMD_FAULT, sb.ws, 8'h00, 44'h0);
    issue(CMD_FAULT, sb.we, 8'h00, 44'h0);
    issue(CMD_FAULT, sb.we + 39'd1, 8'h00, 44'h0);
    issue(CMD_FREE, 39'h0, 8'h00, sb.base);
    issue(CMD_FREE, 39'h0, 8'h00, sb.base + 44'd63);
    issue(CMD_FREE, 39'h0, 8'h00, sb.base + 44'd64);
    issue(CMD_FREE, 39'h0, 8'h00, PPN_MAX);
    issue(3'd5, VA_MAX, 8'hFF, PPN_MAX);
    issue(3'd6, 39'h0, 8'h00, 44'h0);
    issue(3'd7, 39'h0, 8'h00, 44'h0);
    drain();

    // out of pages: fresh root slots until the stack runs dry
    for (int i = 0; i < 24; i++) issue(CMD_MAP, {9'(16 + i), 30'h0}, 8'h00, 44'h0);
    drain();
    for (int i = 1; i < POOL; i++) issue(CMD_FREE, 39'h0, 8'h00, sb.base + 44'(i));
    drain();

    random_phase(100, 1);

    cfg_write(REG_POOL_BASE, 44'h0);
    cfg_write(REG_WIN_START, 44'h0);
    cfg_write(REG_WIN_END, {5'h0, VA_MAX});
    random_phase(100, 1);

    cfg_write(REG_POOL_BASE, PPN_MAX);
    cfg_write(REG_WIN_START, {5'h0, VA_MAX});
    random_phase(100, 1);

    cfg_write(REG_POOL_BASE, 44'd524800);
    cfg_write(REG_WIN_START, 44'hC000_0000);
    cfg_write(REG_WIN_END, 44'hC000_0000);
    random_phase(100, 1);

    cfg_write(REG_POOL_BASE, 44'h123_4567);
    cfg_write(REG_WIN_START, 44'h40_0000_0000);
    cfg_write(REG_WIN_END, 44'h1000);
    random_phase(100, 1);

    // back to reset values so old tables are reachable again, no idling
    cfg_write(REG_POOL_BASE, 44'd524800);
    cfg_write(REG_WIN_START, 44'hC000_0000);
    cfg_write(REG_WIN_END, 44'hD000_0000);
    random_phase(100, 0);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sv39_page_table_mapper_unit test passed");
    end else begin
      $display("sv39_page_table_mapper_unit test failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/ptm_pkg.sv
hw/rtl/ptm_ram.sv
hw/rtl/ptm_walker.sv
hw/rtl/sv39_page_table_mapper_unit.sv
bench/tb_top.sv
